>>> rtl/core/bfa_pkg.sv
// ============================================================================
// bfa_pkg
// Shared sizes, codes and types of the bitmap first-free slot allocator.
// ============================================================================
`default_nettype none

package bfa_pkg;

    // Map geometry: the bitmap is kept as rows of 64 bits
    localparam int SLOTS   = 4096;
    localparam int ROW_W   = 64;
    localparam int ROWS    = SLOTS / ROW_W;
    localparam int ROW_AW  = $clog2(ROWS);
    localparam int BIT_AW  = $clog2(ROW_W);
    localparam int SLOT_AW = ROW_AW + BIT_AW;
    localparam int COUNT_W = $clog2(SLOTS) + 1;
    localparam int BASE_W  = 16;
    localparam int RES_W   = 17;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;

    // Request actions
    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_MARK   = 2'd2,
        ACT_FORMAT = 2'd3
    } action_t;

    // Register indexes on the config port
    localparam logic [CFG_AW-1:0] CFG_RESERVED = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_BASE     = 2'd1;

    // Operations of the row modify unit
    typedef enum logic [1:0] {
        OP_FIND_SET = 2'd0,
        OP_SET      = 2'd1,
        OP_CLEAR    = 2'd2
    } word_op_t;

    // Write request into the map store
    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] addr;
        logic [ROW_W-1:0]  data;
    } map_wr_t;

    // Answer of the row modify unit
    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] pos;
        logic              hit;
        logic [ROW_W-1:0]  word;
    } word_res_t;

endpackage

`default_nettype wire

>>> rtl/core/bfa_map_store.sv
// ============================================================================
// bfa_map_store
// Row memory of the slot bitmap, one write and one registered read a cycle.
// Per-row valid bits make a never-written row read as all clear.
// ============================================================================
`default_nettype none

module bfa_map_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bfa_pkg::map_wr_t            wr,
    input  wire logic [bfa_pkg::ROW_AW-1:0]  rd_addr,
    output logic      [bfa_pkg::ROW_W-1:0]   rd_word
);
    import bfa_pkg::*;

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rd_data_reg;
    logic [ROWS-1:0]  valid_reg;
    logic             rd_valid_reg;

    // Memory array: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Row valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> rtl/core/bfa_word_unit.sv
// ============================================================================
// bfa_word_unit
// Shared row modify unit: finds the lowest clear bit of a row or takes a
// given bit, and returns the row with that bit set or cleared.
// ============================================================================
`default_nettype none

module bfa_word_unit (
    input  wire logic [bfa_pkg::ROW_W-1:0]   word,
    input  wire bfa_pkg::word_op_t           op,
    input  wire logic [bfa_pkg::BIT_AW-1:0]  bit_idx,
    output bfa_pkg::word_res_t               res
);
    import bfa_pkg::*;

    logic [ROW_W-1:0]  clear_bits;
    logic [BIT_AW-1:0] low_pos;
    logic [BIT_AW-1:0] sel_pos;
    logic [ROW_W-1:0]  onehot;

    assign clear_bits = ~word;

    // Lowest clear bit
    always_comb
    begin
        low_pos = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (clear_bits[i])
            begin
                low_pos = BIT_AW'(i);
            end
        end
    end

    assign sel_pos = (op == OP_FIND_SET) ? low_pos : bit_idx;
    assign onehot  = ROW_W'(1) << sel_pos;

    // Modified row
    always_comb
    begin
        res.found = |clear_bits;
        res.pos   = sel_pos;
        res.hit   = word[sel_pos];
        case (op)
            OP_CLEAR: res.word = word & ~onehot;
            default:  res.word = word | onehot;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_first_free_allocator_top.sv
// ============================================================================
// bitmap_first_free_allocator_top
// Bitmap first-fit slot allocator: allocate, free, mark and format requests
// over a 4096-slot map held as 64 rows of 64 bits, with a free-slot count.
// ============================================================================
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  action, slot_index
// m_axis    out  m_axis_tvalid / m_axis_tready  status, result_index, free_count
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// Allocate scans the map one row per cycle through the single read port,
// and skips the scan when the map is already full.
// Free and mark read the row, modify and write it, then give the result; format
// writes every row once.
// Reset clears per-row valid bits at once; no clearing pass is needed.
// The next request is taken while a result still waits on m_axis; a request
// finishing while the output register is full stalls until it drains.
`default_nettype none

module bitmap_first_free_allocator_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // request stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [15:0]                 s_axis_tdata,  // action[1:0], slot_index[13:2]
    // result stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [31:0]                 m_axis_tdata,  // status[0], result_index[17:1],
                                                             // free_count[30:18]
    // config writes
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bfa_pkg::CFG_AW-1:0]  cfg_index,
    input  wire logic [bfa_pkg::CFG_DW-1:0]  cfg_data
);
    import bfa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RMW,
        ST_FMT,
        ST_DONE
    } state_t;

    state_t               state_reg,      state_next;
    logic [ROW_AW-1:0]    row_reg,        row_next;
    action_t              action_reg,     action_next;
    logic [BIT_AW-1:0]    slot_reg,       slot_next;
    logic [COUNT_W-1:0]   count_reg,      count_next;
    logic                 res_status_reg, res_status_next;
    logic [RES_W-1:0]     res_index_reg,  res_index_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [31:0]          out_data_reg,   out_data_next;
    logic [COUNT_W-1:0]   reserved_reg;
    logic [BASE_W-1:0]    base_reg;

    logic                 in_fire;
    action_t              in_action;
    logic [SLOT_AW-1:0]   in_slot;
    map_wr_t              wr;
    logic [ROW_AW-1:0]    rd_addr;
    logic [ROW_W-1:0]     rd_word;
    word_op_t             op;
    word_res_t            unit_res;
    logic [COUNT_W-1:0]   fmt_n;
    logic [ROW_W-1:0]     fmt_word;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_action     = action_t'(s_axis_tdata[1:0]);
    assign in_slot       = s_axis_tdata[13:2];
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Map store and shared row unit
    bfa_map_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_word (rd_word)
    );

    assign op = (state_reg == ST_SCAN) ? OP_FIND_SET :
                (action_reg == ACT_FREE) ? OP_CLEAR : OP_SET;

    bfa_word_unit u_unit (
        .word    (rd_word),
        .op      (op),
        .bit_idx (slot_reg),
        .res     (unit_res)
    );

    // Format row pattern: reserved count saturates at the map size
    assign fmt_n = (reserved_reg > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : reserved_reg;

    always_comb
    begin
        if ({1'b0, row_reg} < fmt_n[COUNT_W-1:BIT_AW])
        begin
            fmt_word = '1;
        end
        else if ({1'b0, row_reg} == fmt_n[COUNT_W-1:BIT_AW])
        begin
            fmt_word = ~({ROW_W{1'b1}} << fmt_n[BIT_AW-1:0]);
        end
        else
        begin
            fmt_word = '0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        action_next     = action_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        rd_addr         = row_reg;
        wr.en           = 1'b0;
        wr.addr         = row_reg;
        wr.data         = unit_res.word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    action_next     = in_action;
                    slot_next       = in_slot[BIT_AW-1:0];
                    res_status_next = 1'b0;
                    res_index_next  = '0;
                    row_next        = '0;
                    rd_addr         = '0;
                    unique case (in_action)
                        ACT_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = 1'b1;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_FREE, ACT_MARK:
                        begin
                            rd_addr    = in_slot[SLOT_AW-1:BIT_AW];
                            row_next   = in_slot[SLOT_AW-1:BIT_AW];
                            state_next = ST_RMW;
                        end
                        ACT_FORMAT:
                        begin
                            state_next = ST_FMT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // row_reg data is on the read port; fetch the next row meanwhile
                rd_addr  = row_reg + 1'b1;
                row_next = row_reg + 1'b1;
                if (unit_res.found)
                begin
                    wr.en          = 1'b1;
                    count_next     = count_reg - 1'b1;
                    res_index_next = RES_W'({row_reg, unit_res.pos}) + RES_W'(base_reg);
                    state_next     = ST_DONE;
                end
                else if (row_reg == ROW_AW'(ROWS - 1))
                begin
                    res_status_next = 1'b1;
                    state_next      = ST_DONE;
                end
            end

            ST_RMW:
            begin
                if (action_reg == ACT_FREE && unit_res.hit)
                begin
                    wr.en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else if (action_reg == ACT_MARK && !unit_res.hit)
                begin
                    wr.en      = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_FMT:
            begin
                wr.en    = 1'b1;
                wr.data  = fmt_word;
                row_next = row_reg + 1'b1;
                if (row_reg == ROW_AW'(ROWS - 1))
                begin
                    count_next = COUNT_W'(SLOTS) - fmt_n;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, count_reg, res_index_reg, res_status_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, registered outputs and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_W'(SLOTS);
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            reserved_reg  <= '0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RESERVED: reserved_reg <= cfg_data[COUNT_W-1:0];
                    CFG_BASE:     base_reg     <= cfg_data[BASE_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        action_reg     <= action_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // free count never exceeds the map size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(SLOTS))
        else $error("free count above map size");

    // a full report carries no slot and a zero free count
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[30:1] == '0))
        else $error("full status with nonzero index or count");

    // no map write while waiting for requests or delivering a result
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !wr.en)
        else $error("map written outside a request");

    // an accepted request other than an allocate on a full map never finishes in the next cycle
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_action != ACT_ALLOC || count_reg != '0)) |=> !(state_reg == ST_IDLE))
        else $error("request dropped by sequencer");

endmodule

`default_nettype wire

>>> verif/tb.sv
// ============================================================================
// tb
// Checks the bitmap first-free slot allocator against an in-bench model of
// its slot map and free count. Request and result channels are
// driven with random idling, and each result is compared field by field.
// ============================================================================
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 80;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 190;
    localparam int MAX_REPORTS    = 10;

    // One result transaction, unpacked
    typedef struct packed {
        logic               status;
        logic [RES_W-1:0]   index;
        logic [COUNT_W-1:0] count;
    } alloc_result_t;

    // Model of the slot map plus the queue of results it predicts
    class slot_ledger;
        bit [SLOTS-1:0] used_map;
        int             free_cnt;
        int             reserved;
        int             base;
        alloc_result_t  pending_results[$];
        int             mismatches;
        int             n_alloc;
        int             n_full;
        int             n_free;
        int             n_mark;
        int             n_format;
        int             n_writes;

        function new();
            used_map   = '0;
            free_cnt   = SLOTS;
            reserved   = 0;
            base       = 0;
            mismatches = 0;
            n_alloc    = 0;
            n_full     = 0;
            n_free     = 0;
            n_mark     = 0;
            n_format   = 0;
            n_writes   = 0;
        endfunction

        function void load_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            n_writes++;
            if (idx == CFG_RESERVED)
                reserved = int'(val[12:0]);
            else if (idx == CFG_BASE)
                base = int'(val);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void take_request(action_t act, logic [SLOT_AW-1:0] slot);
            alloc_result_t r;
            int            s;
            int            i;
            int            n;
            r = '0;
            case (act)
                ACT_ALLOC:
                begin
                    s = -1;
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (!used_map[i])
                        begin
                            s = i;
                            break;
                        end
                    end
                    if (s < 0)
                    begin
                        r.status = 1'b1;
                        n_full++;
                    end
                    else
                    begin
                        used_map[s] = 1'b1;
                        if (free_cnt > 0)
                            free_cnt--;
                        r.index = RES_W'(s + base);
                        n_alloc++;
                    end
                end
                ACT_FREE:
                begin
                    n_free++;
                    if (int'(slot) < SLOTS && used_map[slot])
                    begin
                        used_map[slot] = 1'b0;
                        free_cnt++;
                    end
                end
                ACT_MARK:
                begin
                    n_mark++;
                    if (int'(slot) < SLOTS && !used_map[slot])
                    begin
                        used_map[slot] = 1'b1;
                        if (free_cnt > 0)
                            free_cnt--;
                    end
                end
                default:
                begin
                    // format: clear all, then reserve the lowest slots (saturating)
                    n_format++;
                    n = (reserved > SLOTS) ? SLOTS : reserved;
                    used_map = '0;
                    for (i = 0; i < n; i++)
                        used_map[i] = 1'b1;
                    free_cnt = SLOTS - n;
                end
            endcase
            r.count = COUNT_W'(free_cnt);
            pending_results.push_back(r);
        endfunction

        // Compare one result transaction with the oldest prediction
        function void match_result(logic [31:0] d);
            alloc_result_t got;
            alloc_result_t want;
            got.status = d[0];
            got.index  = d[17:1];
            got.count  = d[30:18];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result with nothing expected: status=%0d index=%0d count=%0d",
                             $time, got.status, got.index, got.count);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.count !== want.count)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] mismatch: expected status=%0d index=%0d count=%0d, got status=%0d index=%0d count=%0d",
                             $time, want.status, want.index, want.count,
                             got.status, got.index, got.count);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;   // action[1:0], slot_index[13:2]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;         // status[0], result_index[17:1],
                                               // free_count[30:18]
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [CFG_AW-1:0]   cfg_index     = '0;
    logic [CFG_DW-1:0]   cfg_data      = '0;

    int                  src_idle      = 32;
    int                  snk_idle      = 74;
    int                  cur_res       = 0;
    int                  quiet_cycles  = 0;
    slot_ledger          board;

    bitmap_first_free_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: random back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.match_result(m_axis_tdata);
    end

    // Watchdog: cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one request; valid stays high afterwards unless the next call idles
    task automatic send_req(action_t act, logic [SLOT_AW-1:0] slot);
        if ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, slot, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.take_request(act, slot);
    endtask

    // Stop requests and wait for every predicted result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.load_reg(idx, val);
    endtask

    // Registers change only with the block idle
    task automatic set_config(int res, int base_val);
        drain();
        write_reg(CFG_RESERVED, CFG_DW'(res));
        write_reg(CFG_BASE, CFG_DW'(base_val));
        cfg_valid <= 1'b0;
        cur_res = res;
    endtask

    // Stimulus
    initial
    begin
        int                 p;
        int                 k;
        int                 r;
        int                 lo;
        action_t            act;
        logic [SLOT_AW-1:0] slot;

        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each action and the corner cases
        set_config(0, 0);
        send_req(ACT_FREE, 12'd0);      // free of a free slot
        send_req(ACT_ALLOC, 12'd0);     // slot 0
        send_req(ACT_ALLOC, 12'hfff);   // slot 1, index ignored
        send_req(ACT_MARK, 12'd2);      // mark of a free slot
        send_req(ACT_MARK, 12'd2);      // mark of a used slot
        send_req(ACT_ALLOC, 12'd0);     // slot 3
        send_req(ACT_FREE, 12'd1);
        send_req(ACT_FREE, 12'd1);
        send_req(ACT_ALLOC, 12'd0);     // slot 1 again
        send_req(ACT_MARK, 12'hfff);
        send_req(ACT_FREE, 12'hfff);
        set_config(SLOTS, 65535);
        send_req(ACT_FORMAT, 12'd0);    // whole map reserved
        send_req(ACT_ALLOC, 12'd0);     // full
        send_req(ACT_FREE, 12'hfff);
        send_req(ACT_ALLOC, 12'd0);     // top slot plus largest base
        send_req(ACT_ALLOC, 12'd0);     // full again
        send_req(ACT_MARK, 12'd0);
        set_config(8191, 1);
        send_req(ACT_FORMAT, 12'hfff);  // reserve count saturates
        send_req(ACT_ALLOC, 12'd0);
        set_config(SLOTS - 1, 0);
        send_req(ACT_FORMAT, 12'd0);
        send_req(ACT_ALLOC, 12'd0);     // only the top slot is left
        send_req(ACT_FREE, 12'd0);

        // Random phases, each under its own register setting
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 2)
            begin
                src_idle = 32;
                snk_idle = 74;
            end
            else if (p < 4)
            begin
                src_idle = 74;
                snk_idle = 32;
            end
            else
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            case (p)
                0:       set_config(0, 0);
                1:       set_config(3968, 65535);
                2:       set_config($urandom_range(SLOTS), $urandom_range(65535));
                3:       set_config($urandom_range(8191, SLOTS + 1), $urandom_range(65535));
                4:       set_config(64, $urandom_range(65535));
                default: set_config($urandom_range(SLOTS, 3900), 0);
            endcase
            send_req(ACT_FORMAT, SLOT_AW'($urandom_range(4095)));
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(99);
                if (r < 45)
                    act = ACT_ALLOC;
                else if (r < 75)
                    act = ACT_FREE;
                else if (r < 97)
                    act = ACT_MARK;
                else
                    act = ACT_FORMAT;
                // slot targets cluster where the map is busy
                r = $urandom_range(99);
                if (r < 40)
                    slot = SLOT_AW'($urandom_range(255));
                else if (r < 60)
                begin
                    lo = (cur_res >= 4064) ? 4032 : ((cur_res < 32) ? 0 : cur_res - 32);
                    slot = SLOT_AW'(lo + $urandom_range(63));
                end
                else if (r < 80)
                    slot = SLOT_AW'(4032 + $urandom_range(63));
                else
                    slot = SLOT_AW'($urandom_range(4095));
                send_req(act, slot);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d allocations, %0d full answers, %0d frees, %0d marks, %0d formats",
                 board.n_alloc, board.n_full, board.n_free, board.n_mark, board.n_format);
        $display("register writes: %0d, mismatches: %0d, results outstanding: %0d",
                 board.n_writes, board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_map_store.sv
rtl/core/bfa_word_unit.sv
rtl/core/bitmap_first_free_allocator_top.sv
verif/tb.sv
